FILE: src/per_flow_round_robin_frame_queue_unit_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the per-flow round-robin frame queue
// Concurrent checks that compile away in synthesis builds.
// ----------------------------------------------------------------------------
`ifndef PER_FLOW_ROUND_ROBIN_FRAME_QUEUE_UNIT_DEFINES_SVH
`define PER_FLOW_ROUND_ROBIN_FRAME_QUEUE_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
`define PFRR_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pfrr check failed");
`define PFRR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pfrr check failed");
`else
`define PFRR_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define PFRR_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

FILE: src/pfrr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfrr_pkg
// Shared constants and types of the per-flow round-robin frame queue.
// ----------------------------------------------------------------------------
package pfrr_pkg;

    localparam int FLOW_COUNT  = 16;
    localparam int FRAME_SLOTS = 256;

    localparam int FLOW_W  = $clog2(FLOW_COUNT);
    localparam int SLOT_W  = $clog2(FRAME_SLOTS);
    localparam int PTR_W   = SLOT_W + 1;
    localparam int CNT_W   = SLOT_W + 1;
    localparam int FILL_W  = FLOW_W + 1;
    localparam int BYTE_W  = 24;
    localparam int EXACT_W = BYTE_W + FLOW_W;
    localparam int ACT_W   = 3;
    localparam int STAT_W  = 3;
    localparam int THR_W   = 9;
    localparam int TAG_W   = 16;
    localparam int SIZE_W  = 16;

    localparam logic [THR_W-1:0]  THR_RESET = THR_W'(192);
    localparam logic [BYTE_W-1:0] BYTE_MAX  = '1;

    localparam logic [ACT_W-1:0] ACT_ENQUEUE = 3'd0;
    localparam logic [ACT_W-1:0] ACT_DEQUEUE = 3'd1;
    localparam logic [ACT_W-1:0] ACT_REMOVE  = 3'd2;
    localparam logic [ACT_W-1:0] ACT_START   = 3'd3;
    localparam logic [ACT_W-1:0] ACT_STOP    = 3'd4;

    localparam logic [STAT_W-1:0] ST_OK       = 3'd0;
    localparam logic [STAT_W-1:0] ST_STOPPED  = 3'd1;
    localparam logic [STAT_W-1:0] ST_FULL     = 3'd2;
    localparam logic [STAT_W-1:0] ST_NOTHING  = 3'd3;
    localparam logic [STAT_W-1:0] ST_EMPTY_FR = 3'd4;

    typedef struct packed {
        logic capture;
        logic read;
        logic commit;
        logic walk;
    } pfrr_cmd_t;

    typedef struct packed {
        logic walk_needed;
        logic walk_done;
    } pfrr_sts_t;

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_READ   = 5'b00010,
        S_COMMIT = 5'b00100,
        S_WALK   = 5'b01000,
        S_REPORT = 5'b10000
    } pfrr_state_t;

endpackage

FILE: src/pfrr_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfrr_ctrl
// Sequencer: accept, slot memory read, commit, ring compaction, report.
// ----------------------------------------------------------------------------
module pfrr_ctrl
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  pfrr_pkg::pfrr_sts_t sts,
    output pfrr_pkg::pfrr_cmd_t cmd,
    output logic               busy,
    output logic               done
);
    import pfrr_pkg::*;

    pfrr_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_READ;
                end
            end
            S_READ:
            begin
                cmd.read   = 1'b1;
                state_next = S_COMMIT;
            end
            S_COMMIT:
            begin
                cmd.commit = 1'b1;
                state_next = sts.walk_needed ? S_WALK : S_REPORT;
            end
            S_WALK:
            begin
                cmd.walk = 1'b1;
                if (sts.walk_done)
                begin
                    state_next = S_REPORT;
                end
            end
            S_REPORT:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != S_IDLE);
    assign done = (state_reg == S_REPORT);

endmodule

FILE: src/pfrr_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfrr_datapath
// Flow tables, ready ring, slot pool memories, totals and result registers.
// ----------------------------------------------------------------------------
module pfrr_datapath
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  pfrr_pkg::pfrr_cmd_t            cmd,
    output pfrr_pkg::pfrr_sts_t            sts,
    input  logic [pfrr_pkg::ACT_W-1:0]     action,
    input  logic [pfrr_pkg::FLOW_W-1:0]    flow_id,
    input  logic [pfrr_pkg::TAG_W-1:0]     frame_tag,
    input  logic [pfrr_pkg::SIZE_W-1:0]    frame_len,
    input  logic                           thr_we,
    input  logic [pfrr_pkg::THR_W-1:0]     thr_wdata,
    output logic [pfrr_pkg::STAT_W-1:0]    res_status,
    output logic                           res_valid,
    output logic [pfrr_pkg::FLOW_W-1:0]    res_flow,
    output logic [pfrr_pkg::TAG_W-1:0]     res_tag,
    output logic [pfrr_pkg::SIZE_W-1:0]    res_size,
    output logic [pfrr_pkg::CNT_W-1:0]     res_queued_frames,
    output logic [pfrr_pkg::BYTE_W-1:0]    res_queued_bytes,
    output logic                           res_over,
    output logic [pfrr_pkg::CNT_W-1:0]     res_rem_frames,
    output logic [pfrr_pkg::BYTE_W-1:0]    res_rem_bytes
);
    import pfrr_pkg::*;

    // latched transaction
    logic [ACT_W-1:0]  act_reg;
    logic [FLOW_W-1:0] flow_reg;
    logic [TAG_W-1:0]  tag_reg;
    logic [SIZE_W-1:0] size_reg;

    logic             running_reg;
    logic [THR_W-1:0] thr_reg;

    // free chain: linked list, then never-used slots from fresh_reg upwards
    logic [PTR_W-1:0] free_head_reg;
    logic [PTR_W-1:0] fresh_reg;

    logic [SLOT_W-1:0] head_reg  [FLOW_COUNT];
    logic [SLOT_W-1:0] tail_reg  [FLOW_COUNT];
    logic [CNT_W-1:0]  count_reg [FLOW_COUNT];
    logic [BYTE_W-1:0] fbytes_reg[FLOW_COUNT];
    logic [FLOW_COUNT-1:0] in_ring_reg;

    logic [FLOW_W-1:0] ring_reg [FLOW_COUNT];
    logic [FLOW_W-1:0] rp_reg;
    logic [FILL_W-1:0] fill_reg;

    logic [CNT_W-1:0]   total_frames_reg;
    logic [EXACT_W-1:0] total_exact_reg;

    logic [FILL_W-1:0] widx_reg;
    logic [FILL_W-1:0] wn_reg;

    // slot pool
    logic [PTR_W-1:0]        next_mem [FRAME_SLOTS];
    logic [TAG_W+SIZE_W-1:0] pay_mem  [FRAME_SLOTS];
    logic [PTR_W-1:0]        next_rd_reg;
    logic [TAG_W+SIZE_W-1:0] pay_rd_reg;

    logic                    next_we;
    logic [SLOT_W-1:0]       next_waddr;
    logic [PTR_W-1:0]        next_wdata;
    logic                    pay_we;
    logic [SLOT_W-1:0]       rd_addr;

    logic [FLOW_W-1:0]  deq_f;
    logic [FLOW_W-1:0]  cur_f;
    logic [BYTE_W-1:0]  old_bytes;
    logic [CNT_W-1:0]   old_count;
    logic [BYTE_W:0]    add_sum;
    logic [BYTE_W-1:0]  enq_bytes;
    logic [BYTE_W-1:0]  deq_bytes;
    logic [BYTE_W-1:0]  pop_size;
    logic [SLOT_W-1:0]  alloc_slot;
    logic [FLOW_W-1:0]  push_idx;
    logic [FLOW_W-1:0]  walk_rd;
    logic [FLOW_W-1:0]  walk_wr;
    logic [FLOW_W-1:0]  walk_e;
    logic               enq_ok;
    logic               deq_ok;
    logic               walk_done;
    logic [CNT_W-1:0]   total_inc;

    always_comb
    begin
        deq_f      = ring_reg[rp_reg];
        cur_f      = (act_reg == ACT_DEQUEUE) ? deq_f : flow_reg;
        rd_addr    = (act_reg == ACT_DEQUEUE) ? head_reg[deq_f] : free_head_reg[SLOT_W-1:0];
        old_bytes  = fbytes_reg[cur_f];
        old_count  = count_reg[cur_f];
        add_sum    = {1'b0, old_bytes} + (BYTE_W+1)'(size_reg);
        enq_bytes  = add_sum[BYTE_W] ? BYTE_MAX : add_sum[BYTE_W-1:0];
        pop_size   = BYTE_W'(pay_rd_reg[SIZE_W-1:0]);
        deq_bytes  = (old_bytes >= pop_size) ? (old_bytes - pop_size) : '0;
        alloc_slot = free_head_reg[PTR_W-1] ? fresh_reg[SLOT_W-1:0]
                                            : free_head_reg[SLOT_W-1:0];
        push_idx   = rp_reg + fill_reg[FLOW_W-1:0];
        walk_rd    = rp_reg + widx_reg[FLOW_W-1:0];
        walk_wr    = rp_reg + wn_reg[FLOW_W-1:0];
        walk_e     = ring_reg[walk_rd];
        walk_done  = (widx_reg == fill_reg);
        enq_ok     = (size_reg != '0) && running_reg && !total_frames_reg[CNT_W-1];
        deq_ok     = (fill_reg != '0) && (count_reg[deq_f] != '0);
        total_inc  = total_frames_reg + CNT_W'(1);
    end

    assign sts.walk_needed = (act_reg == ACT_REMOVE) && in_ring_reg[flow_reg];
    assign sts.walk_done   = walk_done;

    // slot chain write port
    always_comb
    begin
        next_we    = 1'b0;
        next_waddr = tail_reg[cur_f];
        next_wdata = free_head_reg;
        pay_we     = 1'b0;
        if (cmd.commit)
        begin
            case (act_reg)
                ACT_ENQUEUE:
                begin
                    pay_we     = enq_ok;
                    next_we    = enq_ok && (old_count != '0);
                    next_wdata = {1'b0, alloc_slot};
                end
                ACT_DEQUEUE:
                begin
                    next_we    = deq_ok;
                    next_waddr = head_reg[deq_f];
                end
                ACT_REMOVE:
                begin
                    next_we = (old_count != '0);
                end
                default:
                begin
                    next_we = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (next_we)
        begin
            next_mem[next_waddr] <= next_wdata;
        end
        if (pay_we)
        begin
            pay_mem[alloc_slot] <= {tag_reg, size_reg};
        end
        if (cmd.read)
        begin
            next_rd_reg <= next_mem[rd_addr];
            pay_rd_reg  <= pay_mem[rd_addr];
        end
    end

    // transaction latch, ring storage and results
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            act_reg  <= action;
            flow_reg <= flow_id;
            tag_reg  <= frame_tag;
            size_reg <= frame_len;
        end
        if (cmd.commit)
        begin
            res_status     <= ST_OK;
            res_valid      <= 1'b0;
            res_flow       <= '0;
            res_tag        <= '0;
            res_size       <= '0;
            res_over       <= 1'b0;
            res_rem_frames <= '0;
            res_rem_bytes  <= '0;
            case (act_reg)
                ACT_ENQUEUE:
                begin
                    if (size_reg == '0)
                    begin
                        res_status <= ST_EMPTY_FR;
                    end
                    else if (!running_reg)
                    begin
                        res_status <= ST_STOPPED;
                    end
                    else if (total_frames_reg[CNT_W-1])
                    begin
                        res_status <= ST_FULL;
                    end
                    else
                    begin
                        res_over <= (total_inc > thr_reg);
                        if (!in_ring_reg[cur_f])
                        begin
                            ring_reg[push_idx] <= cur_f;
                        end
                    end
                end
                ACT_DEQUEUE:
                begin
                    if (!deq_ok)
                    begin
                        res_status <= ST_NOTHING;
                    end
                    else
                    begin
                        res_valid <= 1'b1;
                        res_flow  <= deq_f;
                        res_tag   <= pay_rd_reg[TAG_W+SIZE_W-1:SIZE_W];
                        res_size  <= pay_rd_reg[SIZE_W-1:0];
                        if (old_count != CNT_W'(1))
                        begin
                            ring_reg[push_idx] <= deq_f;
                        end
                    end
                end
                ACT_REMOVE:
                begin
                    res_rem_frames <= old_count;
                    res_rem_bytes  <= old_bytes;
                end
                default:
                begin
                    res_status <= ST_OK;
                end
            endcase
        end
        if (cmd.walk && !walk_done && (walk_e != flow_reg))
        begin
            ring_reg[walk_wr] <= walk_e;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_reg      <= 1'b0;
            thr_reg          <= THR_RESET;
            free_head_reg    <= PTR_W'(FRAME_SLOTS);
            fresh_reg        <= '0;
            in_ring_reg      <= '0;
            rp_reg           <= '0;
            fill_reg         <= '0;
            total_frames_reg <= '0;
            total_exact_reg  <= '0;
            widx_reg         <= '0;
            wn_reg           <= '0;
            for (int i = 0; i < FLOW_COUNT; i++)
            begin
                head_reg[i]   <= '0;
                tail_reg[i]   <= '0;
                count_reg[i]  <= '0;
                fbytes_reg[i] <= '0;
            end
        end
        else
        begin
            if (thr_we)
            begin
                thr_reg <= thr_wdata;
            end
            if (cmd.commit)
            begin
                widx_reg <= '0;
                wn_reg   <= '0;
                case (act_reg)
                    ACT_ENQUEUE:
                    begin
                        if (enq_ok)
                        begin
                            if (free_head_reg[PTR_W-1])
                            begin
                                fresh_reg <= fresh_reg + PTR_W'(1);
                            end
                            else
                            begin
                                free_head_reg <= next_rd_reg;
                            end
                            if (old_count == '0)
                            begin
                                head_reg[cur_f] <= alloc_slot;
                            end
                            tail_reg[cur_f]   <= alloc_slot;
                            count_reg[cur_f]  <= old_count + CNT_W'(1);
                            fbytes_reg[cur_f] <= enq_bytes;
                            total_frames_reg  <= total_inc;
                            total_exact_reg   <= total_exact_reg + EXACT_W'(enq_bytes)
                                                 - EXACT_W'(old_bytes);
                            if (!in_ring_reg[cur_f])
                            begin
                                in_ring_reg[cur_f] <= 1'b1;
                                fill_reg           <= fill_reg + FILL_W'(1);
                            end
                        end
                    end
                    ACT_DEQUEUE:
                    begin
                        if (fill_reg != '0)
                        begin
                            rp_reg             <= rp_reg + FLOW_W'(1);
                            fill_reg           <= fill_reg - FILL_W'(1);
                            in_ring_reg[deq_f] <= 1'b0;
                        end
                        if (deq_ok)
                        begin
                            head_reg[deq_f]    <= next_rd_reg[SLOT_W-1:0];
                            free_head_reg      <= {1'b0, head_reg[deq_f]};
                            count_reg[deq_f]   <= old_count - CNT_W'(1);
                            fbytes_reg[deq_f]  <= deq_bytes;
                            total_frames_reg   <= total_frames_reg - CNT_W'(1);
                            total_exact_reg    <= total_exact_reg - EXACT_W'(old_bytes)
                                                  + EXACT_W'(deq_bytes);
                            // flow still holds frames: back to the tail of the ring
                            if (old_count != CNT_W'(1))
                            begin
                                in_ring_reg[deq_f] <= 1'b1;
                                fill_reg           <= fill_reg;
                            end
                        end
                    end
                    ACT_REMOVE:
                    begin
                        if (old_count != '0)
                        begin
                            free_head_reg <= {1'b0, head_reg[cur_f]};
                        end
                        total_frames_reg   <= total_frames_reg - old_count;
                        total_exact_reg    <= total_exact_reg - EXACT_W'(old_bytes);
                        count_reg[cur_f]   <= '0;
                        fbytes_reg[cur_f]  <= '0;
                        head_reg[cur_f]    <= '0;
                        tail_reg[cur_f]    <= '0;
                        in_ring_reg[cur_f] <= 1'b0;
                    end
                    ACT_START, ACT_STOP:
                    begin
                        running_reg      <= (act_reg == ACT_START);
                        free_head_reg    <= PTR_W'(FRAME_SLOTS);
                        fresh_reg        <= '0;
                        in_ring_reg      <= '0;
                        rp_reg           <= '0;
                        fill_reg         <= '0;
                        total_frames_reg <= '0;
                        total_exact_reg  <= '0;
                        for (int i = 0; i < FLOW_COUNT; i++)
                        begin
                            head_reg[i]   <= '0;
                            tail_reg[i]   <= '0;
                            count_reg[i]  <= '0;
                            fbytes_reg[i] <= '0;
                        end
                    end
                    default:
                    begin
                        running_reg <= running_reg;
                    end
                endcase
            end
            // ring compaction, one entry a cycle
            if (cmd.walk)
            begin
                if (walk_done)
                begin
                    fill_reg <= wn_reg;
                end
                else
                begin
                    widx_reg <= widx_reg + FILL_W'(1);
                    if (walk_e != flow_reg)
                    begin
                        wn_reg <= wn_reg + FILL_W'(1);
                    end
                end
            end
        end
    end

    assign res_queued_frames = total_frames_reg;
    assign res_queued_bytes  = (|total_exact_reg[EXACT_W-1:BYTE_W]) ? BYTE_MAX
                               : total_exact_reg[BYTE_W-1:0];

endmodule

FILE: src/per_flow_round_robin_frame_queue_unit.sv
`timescale 1ns / 1ps
`include "per_flow_round_robin_frame_queue_unit_defines.svh"
// ----------------------------------------------------------------------------
// per_flow_round_robin_frame_queue_unit
// Per-flow frame FIFOs in a shared slot pool, served round robin.
// ----------------------------------------------------------------------------
// Usage:
//   A transaction is taken when start is high while busy is low; action,
//   flow_id, frame_tag and frame_len are sampled at that edge.
//   One result per transaction: done is high for exactly one cycle with
//   status, the delivered frame and the totals on the result ports.
//   Most transactions pass through accept, slot memory read, commit and
//   report, with done in the report step.
//   Remove flow of a flow on the ready ring adds a compaction walk of the
//   ring before report: the ring is compacted one entry a cycle.
//   busy stays high through the done cycle; the next transaction can be
//   taken in the cycle after done. warn_threshold is written through
//   warn_threshold_we; the user must write it only while idle, as the
//   block does not enforce it. Reset leaves the block stopped with empty
//   queues and a threshold of 192; no clearing pass is needed. The
//   receiver cannot stall: each result must be taken in its done cycle.
// ----------------------------------------------------------------------------
module per_flow_round_robin_frame_queue_unit
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    output logic                        done,
    input  logic                        warn_threshold_we,
    input  logic [pfrr_pkg::THR_W-1:0]  warn_threshold,
    input  logic [pfrr_pkg::ACT_W-1:0]  action,
    input  logic [pfrr_pkg::FLOW_W-1:0] flow_id,
    input  logic [pfrr_pkg::TAG_W-1:0]  frame_tag,
    input  logic [pfrr_pkg::SIZE_W-1:0] frame_len,
    output logic [pfrr_pkg::STAT_W-1:0] status,
    output logic                        frame_valid,
    output logic [pfrr_pkg::FLOW_W-1:0] out_flow,
    output logic [pfrr_pkg::TAG_W-1:0]  out_tag,
    output logic [pfrr_pkg::SIZE_W-1:0] out_size,
    output logic [pfrr_pkg::CNT_W-1:0]  queued_frames,
    output logic [pfrr_pkg::BYTE_W-1:0] queued_bytes,
    output logic                        over_threshold,
    output logic [pfrr_pkg::CNT_W-1:0]  dropped_frames,
    output logic [pfrr_pkg::BYTE_W-1:0] dropped_bytes
);
    import pfrr_pkg::*;

    pfrr_cmd_t cmd;
    pfrr_sts_t sts;

    pfrr_ctrl u_ctrl
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .sts   (sts),
        .cmd   (cmd),
        .busy  (busy),
        .done  (done)
    );

    pfrr_datapath u_datapath
    (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .sts               (sts),
        .action            (action),
        .flow_id           (flow_id),
        .frame_tag         (frame_tag),
        .frame_len         (frame_len),
        .thr_we            (warn_threshold_we),
        .thr_wdata         (warn_threshold),
        .res_status        (status),
        .res_valid         (frame_valid),
        .res_flow          (out_flow),
        .res_tag           (out_tag),
        .res_size          (out_size),
        .res_queued_frames (queued_frames),
        .res_queued_bytes  (queued_bytes),
        .res_over          (over_threshold),
        .res_rem_frames    (dropped_frames),
        .res_rem_bytes     (dropped_bytes)
    );

    `PFRR_ASSERT_NEXT(a_accept_busy, clk, rst_n, start && !busy, busy && !done)
    `PFRR_ASSERT_NEXT(a_done_single, clk, rst_n, done, !done && !busy)
    `PFRR_ASSERT_SAME(a_valid_ok, clk, rst_n, done && frame_valid, status == ST_OK)
    `PFRR_ASSERT_SAME(a_pending_max, clk, rst_n, done, queued_frames <= CNT_W'(FRAME_SLOTS))

endmodule

FILE: dv/per_flow_round_robin_frame_queue_unit_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// per_flow_round_robin_frame_queue_unit_checker
// Watches the command and result channels, predicts each transaction's
// result from a behavioural copy of the per-flow queues and compares it.
// ----------------------------------------------------------------------------
module per_flow_round_robin_frame_queue_unit_checker
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic                          busy,
    input  logic                          done,
    input  logic                          warn_threshold_we,
    input  logic [pfrr_pkg::THR_W-1:0]    warn_threshold,
    input  logic [pfrr_pkg::ACT_W-1:0]    action,
    input  logic [pfrr_pkg::FLOW_W-1:0]   flow_id,
    input  logic [pfrr_pkg::TAG_W-1:0]    frame_tag,
    input  logic [pfrr_pkg::SIZE_W-1:0]   frame_len,
    input  logic [pfrr_pkg::STAT_W-1:0]   status,
    input  logic                          frame_valid,
    input  logic [pfrr_pkg::FLOW_W-1:0]   out_flow,
    input  logic [pfrr_pkg::TAG_W-1:0]    out_tag,
    input  logic [pfrr_pkg::SIZE_W-1:0]   out_size,
    input  logic [pfrr_pkg::CNT_W-1:0]    queued_frames,
    input  logic [pfrr_pkg::BYTE_W-1:0]   queued_bytes,
    input  logic                          over_threshold,
    input  logic [pfrr_pkg::CNT_W-1:0]    dropped_frames,
    input  logic [pfrr_pkg::BYTE_W-1:0]   dropped_bytes,
    output int                            fail_count,
    output int                            outstanding
);
    import pfrr_pkg::*;

    typedef struct packed {
        logic [STAT_W-1:0] st;
        logic              vld;
        logic [FLOW_W-1:0] fl;
        logic [TAG_W-1:0]  tag;
        logic [SIZE_W-1:0] size;
        logic [CNT_W-1:0]  frames;
        logic [BYTE_W-1:0] bytes;
        logic              over;
        logic [CNT_W-1:0]  rm_frames;
        logic [BYTE_W-1:0] rm_bytes;
    } queue_result_t;

    typedef struct packed {
        logic [TAG_W-1:0]  tag;
        logic [SIZE_W-1:0] size;
    } frame_t;

    // per-flow FIFOs stand in for the linked slot pool
    frame_t           flow_q [FLOW_COUNT][$];
    int unsigned      flow_bytes [FLOW_COUNT];
    logic [FLOW_W-1:0] ready_q [$];
    logic [THR_W-1:0] thr;
    logic             running;
    queue_result_t    expected_results [$];

    function automatic int unsigned held_frames();
        int unsigned n;
        n = 0;
        for (int f = 0; f < FLOW_COUNT; f++) n += flow_q[f].size();
        return n;
    endfunction

    function automatic int unsigned held_bytes();
        int unsigned s;
        s = 0;
        for (int f = 0; f < FLOW_COUNT; f++)
        begin
            s += flow_bytes[f];
            if (s > BYTE_MAX) s = BYTE_MAX;
        end
        return s;
    endfunction

    function automatic void clear_all();
        for (int f = 0; f < FLOW_COUNT; f++)
        begin
            flow_q[f].delete();
            flow_bytes[f] = 0;
        end
        ready_q.delete();
    endfunction

    function automatic queue_result_t predict_queue(logic [ACT_W-1:0] act,
                                                    logic [FLOW_W-1:0] fl,
                                                    logic [TAG_W-1:0] tag,
                                                    logic [SIZE_W-1:0] sz);
        queue_result_t r;
        frame_t        fr;
        logic [FLOW_W-1:0] h;
        r = '0;
        if (act == ACT_ENQUEUE)
        begin
            if (sz == 0) r.st = ST_EMPTY_FR;
            else if (!running) r.st = ST_STOPPED;
            else if (held_frames() >= FRAME_SLOTS) r.st = ST_FULL;
            else
            begin
                fr.tag = tag;
                fr.size = sz;
                flow_q[fl].push_back(fr);
                flow_bytes[fl] += sz;
                if (flow_bytes[fl] > BYTE_MAX) flow_bytes[fl] = BYTE_MAX;
                if (flow_q[fl].size() == 1) ready_q.push_back(fl);
                r.over = held_frames() > thr;
            end
        end
        else if (act == ACT_DEQUEUE)
        begin
            if (ready_q.size() == 0) r.st = ST_NOTHING;
            else
            begin
                h = ready_q[0];
                ready_q.delete(0);
                fr = flow_q[h][0];
                flow_q[h].delete(0);
                r.vld = 1'b1;
                r.fl = h;
                r.tag = fr.tag;
                r.size = fr.size;
                flow_bytes[h] = (flow_bytes[h] >= fr.size) ? flow_bytes[h] - fr.size : 0;
                if (flow_q[h].size() > 0) ready_q.push_back(h);
            end
        end
        else if (act == ACT_REMOVE)
        begin
            r.rm_frames = CNT_W'(flow_q[fl].size());
            r.rm_bytes = BYTE_W'(flow_bytes[fl]);
            flow_q[fl].delete();
            flow_bytes[fl] = 0;
            foreach (ready_q[i])
                if (ready_q[i] == fl)
                begin
                    ready_q.delete(i);
                    break;
                end
        end
        else if (act == ACT_START || act == ACT_STOP)
        begin
            clear_all();
            running = (act == ACT_START);
        end
        r.frames = CNT_W'(held_frames());
        r.bytes = BYTE_W'(held_bytes());
        return r;
    endfunction

    queue_result_t got;
    queue_result_t exp_r;

    assign outstanding = expected_results.size();
    assign got = '{status, frame_valid, out_flow, out_tag, out_size, queued_frames,
                   queued_bytes, over_threshold, dropped_frames, dropped_bytes};

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_all();
            expected_results.delete();
            thr = THR_RESET;
            running = 1'b0;
            fail_count <= 0;
        end
        else
        begin
            if (warn_threshold_we) thr = warn_threshold;
            if (start && !busy)
                expected_results.push_back(predict_queue(action, flow_id,
                                                         frame_tag, frame_len));
            if (done)
            begin
                if (expected_results.size() == 0)
                begin
                    $display("%0t: unexpected result %p", $time, got);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    exp_r = expected_results[0];
                    expected_results.delete(0);
                    if (exp_r != got)
                    begin
                        $display("%0t: mismatch expected %p actual %p", $time, exp_r, got);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end

endmodule

FILE: dv/per_flow_round_robin_frame_queue_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// per_flow_round_robin_frame_queue_unit_tb
// Directed and random enqueue/dequeue/remove/start/stop traffic with bursty
// gaps and several threshold settings; results are checked by the checker.
// ----------------------------------------------------------------------------
module per_flow_round_robin_frame_queue_unit_tb;
    import pfrr_pkg::*;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic               done;
    logic               warn_threshold_we = 1'b0;
    logic [THR_W-1:0]   warn_threshold = '0;
    logic [ACT_W-1:0]   action = '0;
    logic [FLOW_W-1:0]  flow_id = '0;
    logic [TAG_W-1:0]   frame_tag = '0;
    logic [SIZE_W-1:0]  frame_len = '0;
    logic [STAT_W-1:0]  status;
    logic               frame_valid;
    logic [FLOW_W-1:0]  out_flow;
    logic [TAG_W-1:0]   out_tag;
    logic [SIZE_W-1:0]  out_size;
    logic [CNT_W-1:0]   queued_frames;
    logic [BYTE_W-1:0]  queued_bytes;
    logic               over_threshold;
    logic [CNT_W-1:0]   dropped_frames;
    logic [BYTE_W-1:0]  dropped_bytes;
    int                 fail_count;
    int                 outstanding;
    int                 burst_left = 0;

    always #10 clk = ~clk;

    per_flow_round_robin_frame_queue_unit dut (.*);
    per_flow_round_robin_frame_queue_unit_checker u_checker (.*);

    // one transaction; start stays high back to back within a burst
    task automatic issue(logic [ACT_W-1:0] act, logic [FLOW_W-1:0] fl,
                         logic [TAG_W-1:0] tag, logic [SIZE_W-1:0] sz);
        int gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(0, 6);
            if (gap > 0)
            begin
                start <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        // fields change only while idle, so a held start never repeats one
        while (busy) @(negedge clk);
        start <= 1'b1;
        action <= act;
        flow_id <= fl;
        frame_tag <= tag;
        frame_len <= sz;
        @(negedge clk);
    endtask

    task automatic quiesce_and_set(logic [THR_W-1:0] value);
        start <= 1'b0;
        while (outstanding != 0) @(negedge clk);
        repeat (25) @(negedge clk);
        warn_threshold_we <= 1'b1;
        warn_threshold <= value;
        @(negedge clk);
        warn_threshold_we <= 1'b0;
    endtask

    task automatic random_phase(int n, int fill_bias);
        int r;
        logic [FLOW_W-1:0] fl;
        logic [TAG_W-1:0]  tg;
        logic [SIZE_W-1:0] sz;
        for (int i = 0; i < n; i++)
        begin
            r = $urandom_range(0, 99);
            fl = FLOW_W'($urandom);
            tg = TAG_W'($urandom);
            sz = SIZE_W'($urandom);
            if (r < fill_bias)
            begin
                if ($urandom_range(0, 30) == 0) sz = '0;
                else if ($urandom_range(0, 9) == 0) sz = 16'hFFFF;
                else sz = SIZE_W'($urandom_range(1, 65535));
                issue(ACT_ENQUEUE, fl, tg, sz);
            end
            else if (r < 90) issue(ACT_DEQUEUE, fl, tg, sz);
            else if (r < 95) issue(ACT_REMOVE, fl, tg, sz);
            else if (r < 97) issue(ACT_START, fl, tg, sz);
            else if (r < 98) issue(ACT_STOP, fl, tg, sz);
            else issue(ACT_W'($urandom_range(5, 7)), fl, tg, sz);
        end
    endtask

    initial
    begin
        repeat (6) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        // directed: stopped, empty frame, nothing ready, then basic traffic
        issue(ACT_ENQUEUE, 4'd1, 16'h1234, 16'd10);
        issue(ACT_ENQUEUE, 4'd1, 16'h1234, 16'd0);
        issue(ACT_DEQUEUE, 4'd0, 16'h0, 16'h0);
        issue(ACT_START, 4'd0, 16'h0, 16'h0);
        issue(ACT_ENQUEUE, 4'd0, 16'hFFFF, 16'hFFFF);
        issue(ACT_ENQUEUE, 4'd15, 16'h0000, 16'd1);
        issue(ACT_ENQUEUE, 4'd15, 16'hA5A5, 16'hFFFF);
        issue(ACT_ENQUEUE, 4'd7, 16'h5A5A, 16'd300);
        issue(ACT_DEQUEUE, 4'd0, 16'h0, 16'h0);
        issue(ACT_REMOVE, 4'd15, 16'h0, 16'h0);
        issue(ACT_REMOVE, 4'd9, 16'h0, 16'h0);
        issue(ACT_REMOVE, 4'd0, 16'h0, 16'h0);
        issue(3'd5, 4'd0, 16'h0, 16'h0);
        issue(3'd7, 4'd3, 16'h0, 16'h0);
        issue(ACT_DEQUEUE, 4'd0, 16'h0, 16'h0);
        issue(ACT_DEQUEUE, 4'd0, 16'h0, 16'h0);
        issue(ACT_STOP, 4'd0, 16'h0, 16'h0);
        issue(ACT_ENQUEUE, 4'd2, 16'h1, 16'h1);
        issue(ACT_START, 4'd0, 16'h0, 16'h0);
        // fill the pool past threshold 0 and to full, pool full rejects
        quiesce_and_set(9'd0);
        for (int i = 0; i < 260; i++)
            issue(ACT_ENQUEUE, FLOW_W'($urandom), TAG_W'($urandom),
                  SIZE_W'($urandom_range(60000, 65535)));
        quiesce_and_set(9'd256);
        random_phase(150, 60);
        quiesce_and_set(9'd255);
        random_phase(150, 85);
        quiesce_and_set(THR_W'($urandom_range(1, 40)));
        random_phase(150, 50);
        quiesce_and_set(THR_RESET);
        random_phase(220, 70);
        start <= 1'b0;
        while (outstanding != 0) @(negedge clk);
        repeat (25) @(negedge clk);
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial
    begin
        #5ms;
        $display("Verification failed");
        $finish;
    end

endmodule
